FILE: rtl/leg_foot_kinematics_core_macros.svh
// assertion macros for the leg foot kinematics core
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef LEG_FOOT_KINEMATICS_CORE_MACROS_SVH
`define LEG_FOOT_KINEMATICS_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LFK_ASSERT_IMPLY(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lfk assertion failed");
`define LFK_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lfk assertion failed");
`else
`define LFK_ASSERT_IMPLY(name, clk, rst_n, cond, prop)
`define LFK_ASSERT_NEXT(name, clk, rst_n, cond, prop)
`endif
`endif

FILE: rtl/lfk_pkg.sv
// shared types, constants and arithmetic helpers of the leg foot kinematics core
// no dependencies
package lfk_pkg;

    localparam int CordicSteps = 24;
    localparam int Stages      = CordicSteps + 8;
    localparam int AngW        = 29;
    localparam int XyW         = 33;
    localparam int TrigW       = 22;
    localparam int AccW        = 50;

    localparam logic signed [AngW-1:0] Pi     = 29'sd52707179;
    localparam logic signed [AngW-1:0] HalfPi = 29'sd26353589;
    localparam logic signed [AngW-1:0] TwoPi  = 29'sd105414357;
    localparam logic signed [XyW-1:0]  CordicX0 = 33'sd652032874;

    typedef enum logic [3:0] {
        REG_HIP_X   = 4'd0,
        REG_HIP_Y   = 4'd1,
        REG_ABAD    = 4'd2,
        REG_THIGH   = 4'd3,
        REG_SHANK0  = 4'd4,
        REG_SHANK1  = 4'd5,
        REG_SHANK2  = 4'd6,
        REG_SHANK3  = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [AngW-1:0] z;
        logic                   neg;
    } t_fold;

    typedef struct packed {
        logic [1:0]         leg;
        logic signed [15:0] ra;
        logic signed [15:0] rh;
        logic signed [15:0] rk;
    } t_side;

    function automatic logic signed [AngW-1:0] atan_q24(input int i);
        case (i)
            0:  return 29'sd13176795;
            1:  return 29'sd7778716;
            2:  return 29'sd4110060;
            3:  return 29'sd2086331;
            4:  return 29'sd1047214;
            5:  return 29'sd524117;
            6:  return 29'sd262123;
            7:  return 29'sd131069;
            8:  return 29'sd65536;
            9:  return 29'sd32768;
            10: return 29'sd16384;
            11: return 29'sd8192;
            12: return 29'sd4096;
            13: return 29'sd2048;
            14: return 29'sd1024;
            15: return 29'sd512;
            16: return 29'sd256;
            17: return 29'sd128;
            18: return 29'sd64;
            19: return 29'sd32;
            20: return 29'sd16;
            21: return 29'sd8;
            22: return 29'sd4;
            23: return 29'sd2;
            default: return 29'sd0;
        endcase
    endfunction

    // wrap into [-pi, pi], then fold into [-pi/2, pi/2] with a sign flag
    function automatic t_fold fold_angle(input logic signed [AngW-1:0] a);
        logic signed [AngW-1:0] v;
        t_fold r;
        v = a;
        if (v > Pi) v = v - TwoPi;
        if (v < -Pi) v = v + TwoPi;
        r.neg = 1'b0;
        if (v > HalfPi) begin
            v = v - Pi;
            r.neg = 1'b1;
        end else if (v < -HalfPi) begin
            v = v + Pi;
            r.neg = 1'b1;
        end
        r.z = v;
        return r;
    endfunction

    // round half up, then arithmetic shift
    function automatic logic signed [AccW-1:0] rnd_sh(input logic signed [AccW-1:0] v,
                                                      input int s);
        logic signed [AccW-1:0] h;
        h = '0;
        h[s-1] = 1'b1;
        return (v + h) >>> s;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [AccW-1:0] v);
        if (v > 50'sd8388607) return 24'sh7fffff;
        if (v < -50'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

endpackage

FILE: rtl/lfk_if.sv
// valid/ready channel interfaces of the leg foot kinematics core
// no dependencies
interface lfk_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         leg_select;
    logic signed [15:0] angle_abad;
    logic signed [15:0] angle_hip;
    logic signed [15:0] angle_knee;
    logic signed [15:0] rate_abad;
    logic signed [15:0] rate_hip;
    logic signed [15:0] rate_knee;
    modport source(output valid, leg_select, angle_abad, angle_hip, angle_knee,
                   rate_abad, rate_hip, rate_knee, input ready);
    modport sink(input valid, leg_select, angle_abad, angle_hip, angle_knee,
                 rate_abad, rate_hip, rate_knee, output ready);
endinterface

interface lfk_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] foot_pos_x;
    logic signed [23:0] foot_pos_y;
    logic signed [23:0] foot_pos_z;
    logic signed [23:0] foot_vel_x;
    logic signed [23:0] foot_vel_y;
    logic signed [23:0] foot_vel_z;
    modport source(output valid, foot_pos_x, foot_pos_y, foot_pos_z,
                   foot_vel_x, foot_vel_y, foot_vel_z, input ready);
    modport sink(input valid, foot_pos_x, foot_pos_y, foot_pos_z,
                 foot_vel_x, foot_vel_y, foot_vel_z, output ready);
endinterface

interface lfk_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [17:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/leg_foot_kinematics_core.sv
// leg foot kinematics core: foot position and Jacobian-based foot velocity
// channels i_in (joint sample), o_out (foot result), i_cfg (register writes).
// each accepted item gives one result item; one item enters every cycle while
// i_in.ready is high. the pipeline is made of the 24 cordic stages, run
// as three parallel lanes (abad, hip, hip plus knee), plus range reduction and
// seven multiply / sum / round stages.
// every stage has its own valid bit and advances when it is empty or the next
// stage advances, so bubbles close up and a stalled receiver holds the result
// in the output register while upstream stages keep filling.
// i_in.ready drops only when every stage holds an item.
// i_cfg is always ready; writes to indexes above 7 are ignored. write the
// registers only while no item is in flight.
// synchronous reset clears all valid bits and sets every configuration register to zero.
// depends on lfk_pkg, lfk_if and leg_foot_kinematics_core_macros.svh
`include "leg_foot_kinematics_core_macros.svh"

module leg_foot_kinematics_core import lfk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfk_in_if.sink      i_in,
    lfk_out_if.source   o_out,
    lfk_cfg_if.sink     i_cfg
);

    localparam int P1 = CordicSteps + 1;
    localparam int P2 = CordicSteps + 2;
    localparam int P3 = CordicSteps + 3;
    localparam int P4 = CordicSteps + 4;
    localparam int P5 = CordicSteps + 5;
    localparam int P6 = CordicSteps + 6;
    localparam int P7 = CordicSteps + 7;

    // configuration registers
    logic signed [17:0] r_hip_x, r_hip_y, r_abad;
    logic [16:0]        r_thigh;
    logic [16:0]        r_shank [4];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hip_x <= '0;
            r_hip_y <= '0;
            r_abad  <= '0;
            r_thigh <= '0;
            for (int i = 0; i < 4; i++) r_shank[i] <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_HIP_X:  r_hip_x    <= i_cfg.data;
                REG_HIP_Y:  r_hip_y    <= i_cfg.data;
                REG_ABAD:   r_abad     <= i_cfg.data;
                REG_THIGH:  r_thigh    <= i_cfg.data[16:0];
                REG_SHANK0: r_shank[0] <= i_cfg.data[16:0];
                REG_SHANK1: r_shank[1] <= i_cfg.data[16:0];
                REG_SHANK2: r_shank[2] <= i_cfg.data[16:0];
                REG_SHANK3: r_shank[3] <= i_cfg.data[16:0];
                default: ;
            endcase
        end
    end

    // stage control
    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] w_en;

    always_comb begin
        w_en[Stages-1] = !r_vld[Stages-1] || o_out.ready;
        for (int k = Stages - 2; k >= 0; k--) w_en[k] = !r_vld[k] || w_en[k+1];
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_in.valid;
            for (int k = 1; k < Stages; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // range reduction, lanes: abad, hip, hip plus knee
    logic signed [AngW-1:0] w_ang [3];
    t_fold                  w_fold [3];

    always_comb begin
        w_ang[0] = AngW'(i_in.angle_abad) <<< 11;
        w_ang[1] = AngW'(i_in.angle_hip) <<< 11;
        w_ang[2] = (AngW'(i_in.angle_hip) + AngW'(i_in.angle_knee)) <<< 11;
        for (int j = 0; j < 3; j++) w_fold[j] = fold_angle(w_ang[j]);
    end

    logic signed [XyW-1:0]  r_x    [0:CordicSteps][3];
    logic signed [XyW-1:0]  r_y    [0:CordicSteps][3];
    logic signed [AngW-1:0] r_z    [0:CordicSteps][3];
    logic [2:0]             r_neg  [0:CordicSteps];
    t_side                  r_side [0:CordicSteps];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int j = 0; j < 3; j++) begin
                r_x[0][j]   <= CordicX0;
                r_y[0][j]   <= '0;
                r_z[0][j]   <= w_fold[j].z;
                r_neg[0][j] <= w_fold[j].neg;
            end
            r_side[0] <= '{leg: i_in.leg_select, ra: i_in.rate_abad,
                           rh: i_in.rate_hip, rk: i_in.rate_knee};
        end
    end

    // cordic rotation, one micro-rotation per stage
    for (genvar k = 1; k <= CordicSteps; k++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                for (int j = 0; j < 3; j++) begin
                    if (!r_z[k-1][j][AngW-1]) begin
                        r_x[k][j] <= r_x[k-1][j] - (r_y[k-1][j] >>> (k - 1));
                        r_y[k][j] <= r_y[k-1][j] + (r_x[k-1][j] >>> (k - 1));
                        r_z[k][j] <= r_z[k-1][j] - atan_q24(k - 1);
                    end else begin
                        r_x[k][j] <= r_x[k-1][j] + (r_y[k-1][j] >>> (k - 1));
                        r_y[k][j] <= r_y[k-1][j] - (r_x[k-1][j] >>> (k - 1));
                        r_z[k][j] <= r_z[k-1][j] + atan_q24(k - 1);
                    end
                end
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // p1: round to q.20, unfold, pick the shank length and signed link offset
    logic signed [XyW-1:0] w_cr [3], w_sr [3], w_c [3], w_s [3];
    logic signed [TrigW-1:0] r1_c [3], r1_s [3];
    logic signed [17:0]      r1_lc;
    logic signed [18:0]      r1_ot;
    t_side                   r1_side;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_cr[j] = (r_x[CordicSteps][j] + $signed(XyW'(512))) >>> 10;
            w_sr[j] = (r_y[CordicSteps][j] + $signed(XyW'(512))) >>> 10;
            w_c[j]  = r_neg[CordicSteps][j] ? -w_cr[j] : w_cr[j];
            w_s[j]  = r_neg[CordicSteps][j] ? -w_sr[j] : w_sr[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[P1]) begin
            for (int j = 0; j < 3; j++) begin
                r1_c[j] <= w_c[j][TrigW-1:0];
                r1_s[j] <= w_s[j][TrigW-1:0];
            end
            r1_lc   <= $signed({1'b0, r_shank[r_side[CordicSteps].leg]});
            // left legs have an even number
            r1_ot   <= r_side[CordicSteps].leg[0] ? -19'(r_abad) : 19'(r_abad);
            r1_side <= r_side[CordicSteps];
        end
    end

    // p2: link products
    logic signed [39:0]      r2_lcc23, r2_ltc2, r2_lcs23, r2_lts2;
    logic signed [TrigW-1:0] r2_s1, r2_c1;
    logic signed [18:0]      r2_ot;
    t_side                   r2_side;

    always_ff @(posedge i_clk) begin
        if (w_en[P2]) begin
            r2_lcc23 <= r1_lc * r1_c[2];
            r2_ltc2  <= $signed({1'b0, r_thigh}) * r1_c[1];
            r2_lcs23 <= r1_lc * r1_s[2];
            r2_lts2  <= $signed({1'b0, r_thigh}) * r1_s[1];
            r2_s1    <= r1_s[0];
            r2_c1    <= r1_c[0];
            r2_ot    <= r1_ot;
            r2_side  <= r1_side;
        end
    end

    // p3: planar leg terms a, b, e, f
    logic signed [AccW-1:0]  w3_a, w3_b, w3_e, w3_f;
    logic signed [24:0]      r3_a, r3_b, r3_e, r3_f;
    logic signed [TrigW-1:0] r3_s1, r3_c1;
    logic signed [18:0]      r3_ot;
    t_side                   r3_side;

    always_comb begin
        w3_a = rnd_sh(AccW'(r2_lcc23) + AccW'(r2_ltc2), 16);
        w3_b = rnd_sh(AccW'(r2_lcs23) + AccW'(r2_lts2), 16);
        w3_e = rnd_sh(AccW'(r2_lcc23), 16);
        w3_f = rnd_sh(AccW'(r2_lcs23), 16);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[P3]) begin
            r3_a    <= w3_a[24:0];
            r3_b    <= w3_b[24:0];
            r3_e    <= w3_e[24:0];
            r3_f    <= w3_f[24:0];
            r3_s1   <= r2_s1;
            r3_c1   <= r2_c1;
            r3_ot   <= r2_ot;
            r3_side <= r2_side;
        end
    end

    // p4: abduction rotation products and foot x
    logic signed [18:0]     w4_fox;
    logic signed [AccW-1:0] w4_px;
    logic signed [46:0]     r4_s1a, r4_c1a, r4_s1b, r4_c1b, r4_s1f, r4_c1f;
    logic signed [40:0]     r4_otc1, r4_ots1, r4_arh, r4_erk;
    logic signed [23:0]     r4_px;
    t_side                  r4_side;

    always_comb begin
        // front legs are 0 and 1
        w4_fox = r3_side.leg[1] ? -19'(r_hip_x) : 19'(r_hip_x);
        w4_px  = rnd_sh((AccW'(w4_fox) <<< 4) - AccW'(r3_b), 4);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[P4]) begin
            r4_s1a  <= r3_s1 * r3_a;
            r4_c1a  <= r3_c1 * r3_a;
            r4_s1b  <= r3_s1 * r3_b;
            r4_c1b  <= r3_c1 * r3_b;
            r4_s1f  <= r3_s1 * r3_f;
            r4_c1f  <= r3_c1 * r3_f;
            r4_otc1 <= r3_ot * r3_c1;
            r4_ots1 <= r3_ot * r3_s1;
            r4_arh  <= r3_a * r3_side.rh;
            r4_erk  <= r3_e * r3_side.rk;
            r4_px   <= sat24(w4_px);
            r4_side <= r3_side;
        end
    end

    // p5: foot y, z, jacobian entries, foot vel x
    logic signed [18:0]     w5_loy;
    logic signed [AccW-1:0] w5_ty, w5_tz, w5_py, w5_pz, w5_vx;
    logic signed [AccW-1:0] w5_j10, w5_j20, w5_j11, w5_j12, w5_j21, w5_j22;
    logic signed [27:0]     r5_j10, r5_j20;
    logic signed [24:0]     r5_j11, r5_j12, r5_j21, r5_j22;
    logic signed [23:0]     r5_px, r5_py, r5_pz, r5_vx;
    t_side                  r5_side;

    always_comb begin
        w5_loy = r4_side.leg[0] ? -19'(r_hip_y) : 19'(r_hip_y);
        w5_ty  = AccW'(r4_s1a) + (AccW'(r4_otc1) <<< 4);
        w5_tz  = (AccW'(r4_ots1) <<< 4) - AccW'(r4_c1a);
        w5_py  = rnd_sh(w5_ty + (AccW'(w5_loy) <<< 24), 24);
        w5_pz  = rnd_sh(w5_tz, 24);
        w5_j10 = rnd_sh(-w5_tz, 20);
        w5_j20 = rnd_sh(w5_ty, 20);
        w5_j11 = rnd_sh(-AccW'(r4_s1b), 20);
        w5_j12 = rnd_sh(-AccW'(r4_s1f), 20);
        w5_j21 = rnd_sh(AccW'(r4_c1b), 20);
        w5_j22 = rnd_sh(AccW'(r4_c1f), 20);
        w5_vx  = rnd_sh(-(AccW'(r4_arh) + AccW'(r4_erk)), 14);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[P5]) begin
            r5_j10  <= w5_j10[27:0];
            r5_j20  <= w5_j20[27:0];
            r5_j11  <= w5_j11[24:0];
            r5_j12  <= w5_j12[24:0];
            r5_j21  <= w5_j21[24:0];
            r5_j22  <= w5_j22[24:0];
            r5_px   <= r4_px;
            r5_py   <= sat24(w5_py);
            r5_pz   <= sat24(w5_pz);
            r5_vx   <= sat24(w5_vx);
            r5_side <= r4_side;
        end
    end

    // p6: jacobian times joint rates
    logic signed [43:0] r6_m10, r6_m20;
    logic signed [40:0] r6_m11, r6_m12, r6_m21, r6_m22;
    logic signed [23:0] r6_px, r6_py, r6_pz, r6_vx;

    always_ff @(posedge i_clk) begin
        if (w_en[P6]) begin
            r6_m10 <= r5_j10 * r5_side.ra;
            r6_m11 <= r5_j11 * r5_side.rh;
            r6_m12 <= r5_j12 * r5_side.rk;
            r6_m20 <= r5_j20 * r5_side.ra;
            r6_m21 <= r5_j21 * r5_side.rh;
            r6_m22 <= r5_j22 * r5_side.rk;
            r6_px  <= r5_px;
            r6_py  <= r5_py;
            r6_pz  <= r5_pz;
            r6_vx  <= r5_vx;
        end
    end

    // p7: velocity sums, output register
    logic signed [AccW-1:0] w7_vy, w7_vz;
    logic signed [23:0]     r7_px, r7_py, r7_pz, r7_vx, r7_vy, r7_vz;

    always_comb begin
        w7_vy = rnd_sh(AccW'(r6_m10) + AccW'(r6_m11) + AccW'(r6_m12), 14);
        w7_vz = rnd_sh(AccW'(r6_m20) + AccW'(r6_m21) + AccW'(r6_m22), 14);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[P7]) begin
            r7_px <= r6_px;
            r7_py <= r6_py;
            r7_pz <= r6_pz;
            r7_vx <= r6_vx;
            r7_vy <= sat24(w7_vy);
            r7_vz <= sat24(w7_vz);
        end
    end

    assign o_out.valid      = r_vld[Stages-1];
    assign o_out.foot_pos_x = r7_px;
    assign o_out.foot_pos_y = r7_py;
    assign o_out.foot_pos_z = r7_pz;
    assign o_out.foot_vel_x = r7_vx;
    assign o_out.foot_vel_y = r7_vy;
    assign o_out.foot_vel_z = r7_vz;

    // an empty output register means no stage can be blocking the input
    `LFK_ASSERT_IMPLY(a_ready_when_out_empty, i_clk, i_rst_n, !o_out.valid, i_in.ready)
    `LFK_ASSERT_NEXT(a_accept_fills_first, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0])
    `LFK_ASSERT_NEXT(a_out_held_on_stall, i_clk, i_rst_n, o_out.valid && !o_out.ready,
                     o_out.valid && $stable(o_out.foot_vel_z))

endmodule
